[rtl/lsdrs_pkg.sv]
// ----------------------------------------------------------------------------
// lsdrs_pkg
// shared constants, operation codes and controller/datapath interface types
// for the decimal radix sorter
// ----------------------------------------------------------------------------
`default_nettype none

package lsdrs_pkg;

   localparam int VALUE_W       = 31;
   localparam int RADIX         = 10;
   localparam int DIGIT_W       = 4;
   localparam int MAX_ITEMS_DEF = 64;

   // floor(q / 10) = (q * RECIP) >> RECIP_SHIFT for every q below 2**32
   localparam logic [31:0] RECIP       = 32'hCCCC_CCCD;
   localparam int          RECIP_SHIFT = 35;
   localparam int          QUOT_W      = 28;

   // pipeline operations
   localparam logic [1:0] OP_COUNT   = 2'd0;
   localparam logic [1:0] OP_SCATTER = 2'd1;
   localparam logic [1:0] OP_EMIT    = 2'd2;

   typedef struct packed {
      logic       load;
      logic       clr;
      logic       issue;
      logic [1:0] op;
      logic       prefix;
      logic       flip;
      logic       finish;
   } ctl_cmd_type;

   typedef struct packed {
      logic last_idx;
      logic bkt_last;
      logic more;
      logic pipe_busy;
   } ctl_stat_type;

endpackage

`default_nettype wire

[rtl/lsdrs_ram.sv]
// ----------------------------------------------------------------------------
// lsdrs_ram
// generic simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module lsdrs_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  wire logic                                      clock,
   input  wire logic                                      wr_en,
   input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] wr_addr,
   input  wire logic [Width-1:0]                          wr_data,
   input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] rd_addr,
   output logic      [Width-1:0]                          rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/lsdrs_datapath.sv]
// ----------------------------------------------------------------------------
// lsdrs_datapath
// two ping-pong value stores, digit extraction pipeline, bucket counters
// and the index, bucket and item counters
// ----------------------------------------------------------------------------
`default_nettype none

module lsdrs_datapath #(
   parameter int MaxItems = lsdrs_pkg::MAX_ITEMS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire lsdrs_pkg::ctl_cmd_type            cmd,
   output lsdrs_pkg::ctl_stat_type                stat,
   input  wire logic [lsdrs_pkg::VALUE_W-1:0]     req_value,
   output logic                                   rsp_valid,
   output logic      [lsdrs_pkg::VALUE_W-1:0]     rsp_sorted_value,
   output logic                                   rsp_last_result
);
   import lsdrs_pkg::*;

   localparam int AW = (MaxItems > 1) ? $clog2(MaxItems) : 1;
   localparam int CW = $clog2(MaxItems + 1);
   localparam int WW = 2 * VALUE_W;

   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [AW-1:0]      idx_ff, idx_in;
   logic [DIGIT_W-1:0] bkt_ff, bkt_in;
   logic [CW-1:0]      run_ff, run_in;
   logic               more_ff, more_in;
   logic               sel_ff, sel_in;
   logic [CW-1:0]      bucket_ff [RADIX];
   logic [CW-1:0]      bucket_in [RADIX];

   logic               v1_ff, last1_ff;
   logic [1:0]         op1_ff;
   logic               v2_ff;
   logic [1:0]         op2_ff;
   logic [VALUE_W-1:0] val2_ff, q2_ff;
   logic [QUOT_W-1:0]  quot2_ff;

   logic               load_store;
   logic               last_idx;
   logic [WW-1:0]      a_rd_data, b_rd_data, src_word;
   logic [VALUE_W-1:0] src_val, src_q;
   logic [63:0]        prod;
   logic [QUOT_W-1:0]  quot1;
   logic [VALUE_W-1:0] ten_quot, rem2;
   logic [DIGIT_W-1:0] digit2;
   logic               is_cnt2, is_sct2;
   logic [AW-1:0]      sct_addr;
   logic [WW-1:0]      sct_data;
   logic               a_we, b_we;
   logic [AW-1:0]      a_waddr;
   logic [WW-1:0]      a_wdata;

   assign load_store = cmd.load && (cnt_ff < CW'(MaxItems));
   assign last_idx   = (CW'(idx_ff) == (cnt_ff - CW'(1)));

   // stage 1: read data and divide by ten
   assign src_word = sel_ff ? b_rd_data : a_rd_data;
   assign src_val  = src_word[WW-1:VALUE_W];
   assign src_q    = src_word[VALUE_W-1:0];
   assign prod     = {33'b0, src_q} * {32'b0, RECIP};
   assign quot1    = prod[RECIP_SHIFT +: QUOT_W];

   // stage 2: digit and bucket update
   assign ten_quot = VALUE_W'({quot2_ff, 3'b000}) + VALUE_W'({quot2_ff, 1'b0});
   assign rem2     = q2_ff - ten_quot;
   assign digit2   = rem2[DIGIT_W-1:0];
   assign is_cnt2  = v2_ff && (op2_ff == OP_COUNT);
   assign is_sct2  = v2_ff && (op2_ff == OP_SCATTER);
   assign sct_addr = bucket_ff[digit2][AW-1:0];
   assign sct_data = {val2_ff, VALUE_W'(quot2_ff)};

   assign a_we    = load_store || (is_sct2 && sel_ff);
   assign a_waddr = load_store ? cnt_ff[AW-1:0] : sct_addr;
   assign a_wdata = load_store ? {req_value, req_value} : sct_data;
   assign b_we    = is_sct2 && !sel_ff;

   lsdrs_ram #(.Width(WW), .Depth(MaxItems)) u_store_a (
      .clock   (clock),
      .wr_en   (a_we),
      .wr_addr (a_waddr),
      .wr_data (a_wdata),
      .rd_addr (idx_ff),
      .rd_data (a_rd_data)
   );

   lsdrs_ram #(.Width(WW), .Depth(MaxItems)) u_store_b (
      .clock   (clock),
      .wr_en   (b_we),
      .wr_addr (sct_addr),
      .wr_data (sct_data),
      .rd_addr (idx_ff),
      .rd_data (b_rd_data)
   );

   always_comb begin
      cnt_in  = cnt_ff;
      idx_in  = idx_ff;
      bkt_in  = bkt_ff;
      run_in  = run_ff;
      more_in = more_ff;
      sel_in  = sel_ff;
      for (int k = 0; k < RADIX; k++) begin
         bucket_in[k] = bucket_ff[k];
      end

      if (load_store) begin
         cnt_in = cnt_ff + CW'(1);
         if (req_value != '0) begin
            more_in = 1'b1;
         end
      end
      if (cmd.clr || cmd.prefix) begin
         idx_in = '0;
      end else if (cmd.issue) begin
         idx_in = idx_ff + AW'(1);
      end

      priority if (cmd.clr) begin
         bkt_in = '0;
         run_in = '0;
         for (int k = 0; k < RADIX; k++) begin
            bucket_in[k] = '0;
         end
      end else if (cmd.prefix) begin
         bkt_in            = bkt_ff + DIGIT_W'(1);
         run_in            = run_ff + bucket_ff[bkt_ff];
         bucket_in[bkt_ff] = run_ff;
         more_in           = 1'b0;
      end else if (is_cnt2 || is_sct2) begin
         bucket_in[digit2] = bucket_ff[digit2] + CW'(1);
      end

      if (is_sct2 && (quot2_ff != '0)) begin
         more_in = 1'b1;
      end
      if (cmd.flip) begin
         sel_in = !sel_ff;
      end
      if (cmd.finish) begin
         cnt_in  = '0;
         more_in = 1'b0;
         sel_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         idx_ff  <= '0;
         bkt_ff  <= '0;
         run_ff  <= '0;
         more_ff <= 1'b0;
         sel_ff  <= 1'b0;
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         idx_ff  <= idx_in;
         bkt_ff  <= bkt_in;
         run_ff  <= run_in;
         more_ff <= more_in;
         sel_ff  <= sel_in;
         v1_ff   <= cmd.issue;
         v2_ff   <= v1_ff && (op1_ff != OP_EMIT);
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < RADIX; k++) begin
         bucket_ff[k] <= bucket_in[k];
      end
      op1_ff   <= cmd.op;
      last1_ff <= last_idx;
      op2_ff   <= op1_ff;
      val2_ff  <= src_val;
      q2_ff    <= src_q;
      quot2_ff <= quot1;
   end

   assign rsp_valid        = v1_ff && (op1_ff == OP_EMIT);
   assign rsp_sorted_value = src_val;
   assign rsp_last_result  = rsp_valid && last1_ff;

   assign stat.last_idx  = last_idx;
   assign stat.bkt_last  = (bkt_ff == DIGIT_W'(RADIX - 1));
   assign stat.more      = more_ff;
   assign stat.pipe_busy = v1_ff || v2_ff;

endmodule

`default_nettype wire

[rtl/lsdrs_ctrl.sv]
// ----------------------------------------------------------------------------
// lsdrs_ctrl
// sequencer: load, per-digit count / prefix / scatter passes, then emit
// ----------------------------------------------------------------------------
`default_nettype none

module lsdrs_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic                     req_last_item,
   input  wire lsdrs_pkg::ctl_stat_type  stat,
   output lsdrs_pkg::ctl_cmd_type        cmd,
   output logic                          busy
);
   import lsdrs_pkg::*;

   localparam logic [3:0] ST_IDLE       = 4'd0;
   localparam logic [3:0] ST_START      = 4'd1;
   localparam logic [3:0] ST_CNT_RD     = 4'd2;
   localparam logic [3:0] ST_CNT_DRAIN  = 4'd3;
   localparam logic [3:0] ST_PREFIX     = 4'd4;
   localparam logic [3:0] ST_SCT_RD     = 4'd5;
   localparam logic [3:0] ST_SCT_DRAIN  = 4'd6;
   localparam logic [3:0] ST_EMIT_RD    = 4'd7;
   localparam logic [3:0] ST_EMIT_DRAIN = 4'd8;

   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.op   = OP_COUNT;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load = start;
            if (start && req_last_item) begin
               state_in = ST_START;
            end
         end
         ST_START: begin
            cmd.clr  = 1'b1;
            state_in = stat.more ? ST_CNT_RD : ST_EMIT_RD;
         end
         ST_CNT_RD: begin
            cmd.issue = 1'b1;
            cmd.op    = OP_COUNT;
            if (stat.last_idx) begin
               state_in = ST_CNT_DRAIN;
            end
         end
         ST_CNT_DRAIN: begin
            if (!stat.pipe_busy) begin
               state_in = ST_PREFIX;
            end
         end
         ST_PREFIX: begin
            cmd.prefix = 1'b1;
            if (stat.bkt_last) begin
               state_in = ST_SCT_RD;
            end
         end
         ST_SCT_RD: begin
            cmd.issue = 1'b1;
            cmd.op    = OP_SCATTER;
            if (stat.last_idx) begin
               state_in = ST_SCT_DRAIN;
            end
         end
         ST_SCT_DRAIN: begin
            if (!stat.pipe_busy) begin
               cmd.flip = 1'b1;
               state_in = ST_START;
            end
         end
         ST_EMIT_RD: begin
            cmd.issue = 1'b1;
            cmd.op    = OP_EMIT;
            if (stat.last_idx) begin
               state_in = ST_EMIT_DRAIN;
            end
         end
         ST_EMIT_DRAIN: begin
            if (!stat.pipe_busy) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

`default_nettype wire

[rtl/lsd_decimal_radix_sort.sv]
// ----------------------------------------------------------------------------
// lsd_decimal_radix_sort
// collects a set of values, sorts it by stable base-10 lsd radix sort and
// returns the values in ascending order, final word marked
//
//   channel   ports                                   handshake
//   request   req_value, req_last_item                start && !busy
//   response  rsp_sorted_value, rsp_last_result       rsp_valid, one cycle
//
// a word without the last mark is stored if there is room; busy stays low
// after the last mark, each digit pass over the n stored words runs a clear,
// a count sweep, a prefix over the ten buckets, a scatter sweep through the two
// stores and pipeline drains, one pass per decimal digit of the largest value
// after the clear state results stream out one per cycle, n words, and busy
// falls once the pipeline has drained; the receiver cannot stall, reset clears
// the set
// ----------------------------------------------------------------------------
`default_nettype none

module lsd_decimal_radix_sort #(
   parameter int MaxItems = lsdrs_pkg::MAX_ITEMS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [lsdrs_pkg::VALUE_W-1:0] req_value,
   input  wire logic                          req_last_item,
   output logic                               rsp_valid,
   output logic      [lsdrs_pkg::VALUE_W-1:0] rsp_sorted_value,
   output logic                               rsp_last_result
);
   import lsdrs_pkg::*;

   ctl_cmd_type  cmd;
   ctl_stat_type stat;

   lsdrs_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_last_item (req_last_item),
      .stat          (stat),
      .cmd           (cmd),
      .busy          (busy)
   );

   lsdrs_datapath #(.MaxItems(MaxItems)) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_last_result  (rsp_last_result)
   );

   // results only come out of a running sort
   a_rsp_in_sort: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("response word outside a sort");

   // nothing follows the final word of a run
   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      rsp_last_result |=> !rsp_valid)
      else $error("response word after the final word");

   // a word without the last mark never starts a sort
   a_no_sort_early: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !req_last_item) |=> !busy)
      else $error("sort started before the last word");

   // passes never overlap with loading
   a_no_load_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> !busy)
      else $error("load while busy");

endmodule

`default_nettype wire
